// File: hw/rtl/sprite_frame_animation_timer_assert.svh
// assertion macros for the sprite frame animation timer
// used by the top level; no other dependencies
`ifndef SPRITE_FRAME_ANIMATION_TIMER_ASSERT_SVH
`define SPRITE_FRAME_ANIMATION_TIMER_ASSERT_SVH
`ifndef SYNTH
`define SFAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SFAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/sfat_pkg.sv
// shared constants, types and helpers for the sprite frame animation timer
// no dependencies
`default_nettype none
package sfat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int FRAME_BITS  = 8;
    localparam int TIME_BITS   = 32;
    localparam int CNT_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_BITS    = 4;
    localparam int COUNT_BITS  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYING     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOPING     = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        t_time  sum;
        logic   found;
        t_frame frame;
    } t_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOTAL,
        S_WRAP,
        S_SEARCH,
        S_OUT
    } t_state;

    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfat_cell.sv
// one table entry of the chain: holds duration and frame, adds to the running sum
// depends on sfat_pkg
`default_nettype none
module sfat_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [sfat_pkg::TIME_BITS-1:0]  i_wr_duration,
    input  wire logic [sfat_pkg::FRAME_BITS-1:0] i_wr_frame,
    input  wire logic                        i_active,
    input  wire logic                        i_search,
    input  wire logic [sfat_pkg::TIME_BITS-1:0]  i_elapsed,
    input  wire sfat_pkg::t_link             i_link,
    output sfat_pkg::t_link                  o_link
);
    import sfat_pkg::*;

    t_time  r_duration;
    t_frame r_frame;
    t_link  r_link;
    t_link  n_link;
    t_time  w_run;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_duration <= i_wr_duration;
            r_frame    <= i_wr_frame;
        end
    end

    always_comb begin
        w_run  = i_active ? sat_add(i_link.sum, r_duration) : i_link.sum;
        n_link = i_link;
        n_link.sum = w_run;
        if (i_search && i_active && !i_link.found && (i_elapsed < w_run)) begin
            n_link.found = 1'b1;
            n_link.frame = r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule
`default_nettype wire

// File: hw/rtl/sprite_frame_animation_timer.sv
// sprite frame animation timer: a row of entry cells, one walk for the total
// and one for the frame search, with the sequencer and output register
// depends on sfat_pkg, sfat_cell and sprite_frame_animation_timer_assert.svh
//
// usage:
//   input channel (i_in_valid / o_in_ready) takes one word: a tick or a table
//   write, chosen by i_kind. every word gives exactly one result word on the
//   output channel (o_out_valid / i_out_ready): the shown frame and elapsed time.
//   configuration channel (i_cfg_valid / o_cfg_ready) is always ready; index 0
//   frame count, 1 playing, 2 looping; other indexes are ignored.
//   a table write or a frozen tick skips the walk and goes straight to the output state.
//   a playing tick walks the cell row twice, one cell per cycle: the total
//   walk, a wrap step, then the frame search walk; the next word is taken
//   only after the result is loaded into the output register.
//   the output register lets a new word be accepted while a result waits; the
//   block holds the next result until the receiver takes the previous one.
//   reset clears elapsed time, the shown frame and the registers (looping set);
//   table entries are undefined until written.
`default_nettype none
module sprite_frame_animation_timer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_kind,
    input  wire logic [sfat_pkg::TIME_BITS-1:0]    i_delta,
    input  wire logic [sfat_pkg::IDX_BITS-1:0]     i_entry_index,
    input  wire logic [sfat_pkg::TIME_BITS-1:0]    i_entry_duration,
    input  wire logic [sfat_pkg::FRAME_BITS-1:0]   i_entry_frame,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [sfat_pkg::FRAME_BITS-1:0]        o_shown_frame,
    output logic [sfat_pkg::TIME_BITS-1:0]         o_elapsed_now,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sfat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sfat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sfat_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTRIES - 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [COUNT_BITS-1:0] r_frame_count;
    logic                  r_playing;
    logic                  r_looping;
    t_time                 r_elapsed;
    t_time                 r_delta;
    t_frame                r_cur_frame;
    logic                  r_walked;
    logic                  r_out_valid;
    t_frame                r_out_frame;
    t_time                 r_out_elapsed;

    logic   w_in_fire;
    logic   w_search;
    logic   w_load_out;
    t_time  w_sum;
    t_time  n_elapsed;
    t_frame n_frame;
    t_link  w_link [MAX_ENTRIES+1];

    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (i_kind == KIND_TICK && r_playing) ? S_TOTAL : S_OUT;
                end
            end
            S_TOTAL: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: n_state = S_SEARCH;
            S_SEARCH: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_search   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_TOTAL:  w_search   = 1'b0;
            S_WRAP:   w_search   = 1'b0;
            S_SEARCH: w_search   = 1'b1;
            S_OUT:    w_load_out = !r_out_valid || i_out_ready;
            default:  o_in_ready = 1'b0;
        endcase
    end

    // wrap of elapsed time by the total at the end of the row
    always_comb begin
        w_sum     = sat_add(r_elapsed, r_delta);
        n_elapsed = w_sum;
        if (r_looping && (w_sum > w_link[MAX_ENTRIES].sum)) begin
            n_elapsed = w_sum - w_link[MAX_ENTRIES].sum;
        end
    end

    always_comb begin
        n_frame = r_cur_frame;
        if (r_walked && w_link[MAX_ENTRIES].found) begin
            n_frame = w_link[MAX_ENTRIES].frame;
        end
    end

    assign w_link[0] = '{sum: '0, found: 1'b0, frame: '0};

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        sfat_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr_en       (w_in_fire && (i_kind == KIND_WRITE) &&
                            (int'(i_entry_index) == g)),
            .i_wr_duration (i_entry_duration),
            .i_wr_frame    (i_entry_frame),
            .i_active      (int'(r_frame_count) > g),
            .i_search      (w_search),
            .i_elapsed     (r_elapsed),
            .i_link        (w_link[g]),
            .o_link        (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_frame_count <= '0;
            r_playing     <= 1'b0;
            r_looping     <= 1'b1;
            r_elapsed     <= '0;
            r_cur_frame   <= '0;
            r_walked      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                    REG_PLAYING:     r_playing     <= i_cfg_data[0];
                    REG_LOOPING:     r_looping     <= i_cfg_data[0];
                    default:         r_playing     <= r_playing;
                endcase
            end
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state == S_TOTAL || r_state == S_SEARCH) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_WRAP) begin
                r_elapsed <= n_elapsed;
            end
            if (r_state == S_SEARCH && r_cnt == CNT_LAST) begin
                r_walked <= 1'b1;
            end else if (r_state == S_OUT) begin
                r_walked    <= 1'b0;
                r_cur_frame <= n_frame;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_delta <= i_delta;
        end
        if (w_load_out) begin
            r_out_frame   <= n_frame;
            r_out_elapsed <= r_elapsed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_shown_frame = r_out_frame;
    assign o_elapsed_now = r_out_elapsed;

`include "sprite_frame_animation_timer_assert.svh"

    `SFAT_ASSERT_NEXT(a_frozen_tick_skips_walk, i_clk, i_rst_n, w_in_fire && (i_kind == KIND_TICK) && !r_playing, r_state == S_OUT, "frozen tick started a walk")
    `SFAT_ASSERT_NEXT(a_elapsed_stable_in_search, i_clk, i_rst_n, r_state == S_SEARCH, $stable(r_elapsed), "elapsed moved during the frame search")
    `SFAT_ASSERT_NEXT(a_search_runs_full_row, i_clk, i_rst_n, (r_state == S_SEARCH) && (r_cnt != CNT_LAST), r_state == S_SEARCH, "frame search left the row early")
    `SFAT_ASSERT_NOW(a_load_only_when_free, i_clk, i_rst_n, w_load_out, !r_out_valid || i_out_ready, "result word overwritten before it was taken")

endmodule
`default_nettype wire

// File: dv/sprite_frame_animation_timer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sprite_frame_animation_timer: directed and random ticks and table writes
// predicts shown frame and elapsed time in a scoreboard class; needs only sfat_pkg and the rtl
module sprite_frame_animation_timer_tb;
    import sfat_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_PHASES = 12;
    localparam int WORDS_PER_PHASE = 125;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    class anim_scoreboard;
        logic [COUNT_BITS-1:0] frame_count;
        logic playing;
        logic looping;
        t_time elapsed;
        t_frame shown;
        t_time dur_tab[MAX_ENTRIES];
        t_frame frm_tab[MAX_ENTRIES];
        t_frame frame_q[$];
        t_time elapsed_q[$];
        int fault_count;

        function new();
            frame_count = '0;
            playing = 1'b0;
            looping = 1'b1;
            elapsed = '0;
            shown = '0;
            fault_count = 0;
        endfunction

        function t_time clamp_add(t_time a, t_time b);
            logic [TIME_BITS:0] wide;
            wide = {1'b0, a} + {1'b0, b};
            if (wide[TIME_BITS]) return '1;
            return wide[TIME_BITS-1:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_COUNT: frame_count = data;
                REG_PLAYING: playing = data[0];
                REG_LOOPING: looping = data[0];
                default: ;
            endcase
        endfunction

        function void note_word(logic kind, t_time delta, logic [IDX_BITS-1:0] idx,
                                t_time dur, t_frame frm);
            int used;
            t_time total;
            t_time run;
            if (kind == KIND_WRITE) begin
                dur_tab[idx] = dur;
                frm_tab[idx] = frm;
            end else if (playing) begin
                used = int'(frame_count);
                if (used > MAX_ENTRIES) used = MAX_ENTRIES;
                total = '0;
                for (int i = 0; i < used; i++) total = clamp_add(total, dur_tab[i]);
                elapsed = clamp_add(elapsed, delta);
                if (looping && elapsed > total) elapsed = elapsed - total;
                run = '0;
                for (int i = 0; i < used; i++) begin
                    run = clamp_add(run, dur_tab[i]);
                    if (elapsed < run) begin
                        shown = frm_tab[i];
                        break;
                    end
                end
            end
            frame_q.push_back(shown);
            elapsed_q.push_back(elapsed);
        endfunction

        function void check_result(t_frame frm, t_time el);
            t_frame want_frame;
            t_time want_el;
            if (frame_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected word: frame %0d elapsed %h", frm, el);
                return;
            end
            want_frame = frame_q.pop_front();
            want_el = elapsed_q.pop_front();
            if (want_frame !== frm || want_el !== el) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: frame exp %0d got %0d, elapsed exp %h got %h",
                             want_frame, frm, want_el, el);
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_kind = KIND_TICK;
    t_time i_delta = '0;
    logic [IDX_BITS-1:0] i_entry_index = '0;
    t_time i_entry_duration = '0;
    t_frame i_entry_frame = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_frame o_shown_frame;
    t_time o_elapsed_now;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count = 0;
    anim_scoreboard tracker = new();

    sprite_frame_animation_timer u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_delta(i_delta),
        .i_entry_index(i_entry_index),
        .i_entry_duration(i_entry_duration),
        .i_entry_frame(i_entry_frame),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_shown_frame(o_shown_frame),
        .o_elapsed_now(o_elapsed_now),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_result(o_shown_frame, o_elapsed_now);
    end

    task automatic send_word(input logic kind, input t_time delta,
                             input logic [IDX_BITS-1:0] idx, input t_time dur,
                             input t_frame frm);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_delta <= delta;
        i_entry_index <= idx;
        i_entry_duration <= dur;
        i_entry_frame <= frm;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_word(kind, delta, idx, dur, frm);
    endtask

    task automatic tick(input t_time delta);
        send_word(KIND_TICK, delta, IDX_BITS'($urandom_range(0, 15)), $urandom(),
                  FRAME_BITS'($urandom_range(0, 255)));
    endtask

    task automatic fill_entry(input logic [IDX_BITS-1:0] idx, input t_time dur,
                              input t_frame frm);
        send_word(KIND_WRITE, $urandom(), idx, dur, frm);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic settle_and_configure(input logic [COUNT_BITS-1:0] count, input logic play,
                                        input logic loop, input t_idle_mode mode);
        logic [CFG_DATA_W-1:0] play_bits;
        logic [CFG_DATA_W-1:0] loop_bits;
        play_bits = CFG_DATA_W'($urandom_range(0, 31));
        play_bits[0] = play;
        loop_bits = CFG_DATA_W'($urandom_range(0, 31));
        loop_bits[0] = loop;
        drain();
        cfg_write(REG_FRAME_COUNT, count);
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
        cfg_write(REG_PLAYING, play_bits);
        cfg_write(REG_LOOPING, loop_bits);
        i_cfg_valid <= 1'b0;
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 68;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 68;
            end
            default: begin
                send_idle_pct = 22;
                recv_stall_pct = 22;
            end
        endcase
    endtask

    task automatic send_random_word();
        logic is_write;
        t_time delta;
        t_time dur;
        int unsigned pick;
        is_write = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 75) delta = t_time'($urandom_range(0, 32'h2_0000));
        else if (pick < 83) delta = '0;
        else if (pick < 98) delta = t_time'($urandom_range(0, 32'hFFF));
        else delta = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 70) dur = t_time'($urandom_range(32'h100, 32'h4_0000));
        else if (pick < 85) dur = '0;
        else if (pick < 95) dur = t_time'($urandom_range(0, 32'hFF));
        else dur = $urandom();
        send_word(is_write ? KIND_WRITE : KIND_TICK, delta, IDX_BITS'($urandom_range(0, 15)),
                  dur, FRAME_BITS'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [COUNT_BITS-1:0] count;
        int unsigned pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // frozen tick, then fill the whole table
        settle_and_configure(5'd0, 1'b0, 1'b1, IDLE_NONE);
        tick('1);
        for (int i = 0; i < MAX_ENTRIES; i++)
            fill_entry(IDX_BITS'(i), (i == 3) ? t_time'(0) : t_time'((i + 1) * 32'h8000),
                       FRAME_BITS'(i * 17));

        // empty table while playing
        settle_and_configure(5'd0, 1'b1, 1'b1, IDLE_SENDER);
        tick(32'h1_8000);

        // count above table size, then saturation without looping
        settle_and_configure(5'd31, 1'b1, 1'b0, IDLE_RECEIVER);
        tick(32'h1_0000);
        tick('1);

        // wrap a saturated time back down with one huge entry
        settle_and_configure(5'd1, 1'b1, 1'b1, IDLE_BOTH);
        fill_entry(4'd0, 32'hFFFF_FFFE, 8'hAA);
        tick('0);

        // saturating total and running sums, then restore small entries
        settle_and_configure(5'd16, 1'b1, 1'b1, IDLE_NONE);
        fill_entry(4'd1, '1, 8'h55);
        tick(32'h5);
        fill_entry(4'd0, 32'h8000, 8'h00);
        fill_entry(4'd1, 32'h1_0000, 8'h11);
        tick(32'h1_0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (tracker.elapsed > 32'h0020_0000) begin
                settle_and_configure(5'd1, 1'b1, 1'b1, t_idle_mode'(p % 4));
                fill_entry(4'd0, tracker.elapsed - 1, FRAME_BITS'($urandom_range(0, 255)));
                tick('0);
                fill_entry(4'd0, t_time'($urandom_range(32'h100, 32'h4_0000)),
                           FRAME_BITS'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) count = 0;
            else if (pick == 1) count = 5'd16;
            else if (pick == 2) count = COUNT_BITS'($urandom_range(17, 31));
            else count = COUNT_BITS'($urandom_range(1, 16));
            settle_and_configure(count, $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0,
                                 t_idle_mode'(p % 4));
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 149) == 0) drain();
                send_random_word();
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (tracker.fault_count == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sfat_pkg.sv
hw/rtl/sfat_cell.sv
hw/rtl/sprite_frame_animation_timer.sv
dv/sprite_frame_animation_timer_tb.sv
